>>> rtl/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, character codes and a hex-digit helper function shared by the JSON string
// unescape blocks.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int MAX_RES = 5;
  localparam int CNT_W   = 3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_HEX    = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       string_end;
    logic       last;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0] entry;
    logic [CNT_W-1:0]      count;
  } burst_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    priority if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> rtl/jsu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode
// Escape decoder: holds the escape state and turns the current byte into a
// burst of up to five results.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      in_byte,
  input  logic            advance,
  output jsu_pkg::burst_t burst
);
  import jsu_pkg::*;

  mode_t                 mode_r, mode_nxt;
  logic [1:0]            seen_r, seen_nxt;
  logic [2:0][7:0]       held_r, held_nxt;
  result_t [MAX_RES-1:0] res;
  logic [CNT_W-1:0]      n;
  logic                  do_normal;
  hex_t                  hv;
  hex_t                  h0, h1, h2;
  logic [15:0]           cp;

  assign hv = hex_value(in_byte);
  assign h0 = hex_value(held_r[0]);
  assign h1 = hex_value(held_r[1]);
  assign h2 = hex_value(held_r[2]);
  assign cp = {h0.value, h1.value, h2.value, hv.value};

  always_comb begin
    res       = '0;
    n         = '0;
    mode_nxt  = mode_r;
    seen_nxt  = seen_r;
    held_nxt  = held_r;
    do_normal = 1'b0;
    unique case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_NORMAL;
        priority if (in_byte == CH_NUL) begin
          res[n].string_end = 1'b1;
          n = n + CNT_W'(1);
        end else if (in_byte == CH_N) begin
          res[n].data     = CH_LF;
          res[n].has_byte = 1'b1;
          n = n + CNT_W'(1);
        end else if (in_byte == CH_T) begin
          res[n].data     = CH_TAB;
          res[n].has_byte = 1'b1;
          n = n + CNT_W'(1);
        end else if (in_byte == CH_U) begin
          mode_nxt = MODE_HEX;
          seen_nxt = 2'd0;
        end else begin
          res[n].data     = in_byte;
          res[n].has_byte = 1'b1;
          n = n + CNT_W'(1);
        end
      end
      MODE_HEX: begin
        if (hv.valid) begin
          if (seen_r < 2'd3) begin
            held_nxt[seen_r] = in_byte;
            seen_nxt         = seen_r + 2'd1;
          end else begin
            mode_nxt = MODE_NORMAL;
            seen_nxt = 2'd0;
            if (cp != 16'd0) begin
              priority if (cp < 16'h0080) begin
                res[0].data     = cp[7:0];
                res[0].has_byte = 1'b1;
                n = CNT_W'(1);
              end else if (cp < 16'h0800) begin
                res[0].data     = {3'b110, cp[10:6]};
                res[0].has_byte = 1'b1;
                res[1].data     = {2'b10, cp[5:0]};
                res[1].has_byte = 1'b1;
                n = CNT_W'(2);
              end else begin
                res[0].data     = {4'b1110, cp[15:12]};
                res[0].has_byte = 1'b1;
                res[1].data     = {2'b10, cp[11:6]};
                res[1].has_byte = 1'b1;
                res[2].data     = {2'b10, cp[5:0]};
                res[2].has_byte = 1'b1;
                n = CNT_W'(3);
              end
            end
          end
        end else begin
          res[0].data     = CH_U;
          res[0].has_byte = 1'b1;
          n = CNT_W'(1);
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < seen_r) begin
              res[n].data     = held_r[i];
              res[n].has_byte = 1'b1;
              n = n + CNT_W'(1);
            end
          end
          mode_nxt  = MODE_NORMAL;
          seen_nxt  = 2'd0;
          do_normal = 1'b1;
        end
      end
      default: begin
        mode_nxt  = MODE_NORMAL;
        do_normal = 1'b1;
      end
    endcase

    if (do_normal) begin
      priority if (in_byte == CH_NUL || in_byte == CH_QUOTE) begin
        res[n].string_end = 1'b1;
        n = n + CNT_W'(1);
        mode_nxt = MODE_NORMAL;
      end else if (in_byte == CH_BSL) begin
        mode_nxt = MODE_ESC;
      end else begin
        res[n].data     = in_byte;
        res[n].has_byte = 1'b1;
        n = n + CNT_W'(1);
      end
    end

    for (int i = 0; i < MAX_RES; i++) begin
      if (n != '0 && CNT_W'(i) == n - CNT_W'(1)) begin
        res[i].last = 1'b1;
      end
    end
  end

  assign burst.entry = res;
  assign burst.count = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      seen_r <= 2'd0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held_r <= held_nxt;
    end
  end

endmodule

>>> rtl/jsu_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_emit
// Result buffer: takes a whole burst at once and hands its results to the
// output stream one request per cycle while the output is ready.
// ----------------------------------------------------------------------------
module jsu_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  jsu_pkg::burst_t  burst,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output jsu_pkg::result_t out_res
);
  import jsu_pkg::*;

  result_t [MAX_RES-1:0] buf_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  take;

  assign out_valid = (cnt_r != '0);
  assign take      = out_valid && out_ready;
  assign free      = (cnt_r == '0) || (cnt_r == CNT_W'(1) && out_ready);
  assign out_res   = buf_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= burst.count;
    end else if (take) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= burst.entry;
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

endmodule

>>> rtl/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes the bytes of a JSON string body, resolving escapes and turning
// backslash-u escapes into UTF-8.
// ----------------------------------------------------------------------------
// A byte is taken into an input register, decoded there combinationally into a
// burst of zero to five results, and the burst moves into a result buffer
// that drains one result per cycle while the output is ready. Plain text
// streams at one byte per clock while the output is ready; a byte that yields
// more than one result keeps the result buffer busy until it has drained
// them, while the input register keeps the next byte waiting. Each string
// ends with a result that has string_end set.
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] has_byte, [1] string_end
  output logic       out_tlast   // last_in_run
);
  import jsu_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       load;
  logic       free;
  burst_t     burst;
  result_t    out_res;

  assign load      = in_valid_r && free;
  assign in_tready = !in_valid_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (load) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_byte_r),
    .advance (load),
    .burst   (burst)
  );

  jsu_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .burst     (burst),
    .free      (free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = {out_res.string_end, out_res.has_byte};
  assign out_tlast = out_res.last;

endmodule

>>> rtl/jsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the result stream of the JSON string unescaper.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  // A stalled result request keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Every result is either a byte or an end marker, never both or neither.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] ^ out_tuser[1]))
    else $error("result is neither byte nor end marker");

  // An end marker closes the run of its input byte.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("end marker not last in run");

  // A decoded byte is never zero, and an end marker carries zero data.
  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] ? (out_tdata != 8'h00) : (out_tdata == 8'h00)))
    else $error("bad data value for result kind");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON string unescaper. Bytes go in on a stream
// sender that pauses in bursts. A behavioural decoder predicts the results of
// every accepted byte, and a monitor compares each result against the oldest
// prediction while the receiver stalls on a pattern of its own. Directed
// strings cover plain bytes, simple escapes, unicode escapes and broken
// escapes. Random well-formed strings with some noise follow.
// ----------------------------------------------------------------------------
module tb_top;
  import jsu_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         RANDOM_ITEMS = 450;
  localparam int         DRAIN_CYCLES = 20;
  localparam logic [7:0] CH_SLASH     = 8'h2F;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  // Decoder state of the prediction.
  mode_t      dec_mode = MODE_NORMAL;
  logic [1:0] hex_count = 2'd0;
  logic [7:0] held_hex [3];

  result_t    run_results [$];
  result_t    pending_results [$];

  int         errors = 0;
  int         cycles = 0;
  int         bytes_sent = 0;
  int         burst_left = 0;
  int         ready_style = 0;
  int         style_left = 0;
  int         stall_left = 0;

  json_string_unescape_utf8 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Receiver: stretches of full readiness, random readiness and long stalls.
  always @(posedge clk) begin
    if (style_left == 0) begin
      ready_style = $urandom_range(0, 3);
      style_left = $urandom_range(20, 120);
    end else begin
      style_left = style_left - 1;
    end
    case (ready_style)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left = stall_left - 1;
          out_tready <= 1'b0;
        end else begin
          stall_left = $urandom_range(0, 8);
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.data = out_tdata;
      got.has_byte = out_tuser[0];
      got.string_end = out_tuser[1];
      got.last = out_tlast;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result data=%h has_byte=%b string_end=%b last=%b",
                 $time, got.data, got.has_byte, got.string_end, got.last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.data !== want.data || got.has_byte !== want.has_byte ||
            got.string_end !== want.string_end || got.last !== want.last) begin
          $display("%0t: mismatch expected data=%h has_byte=%b string_end=%b last=%b",
                   $time, want.data, want.has_byte, want.string_end, want.last);
          $display("%0t:          actual   data=%h has_byte=%b string_end=%b last=%b",
                   $time, got.data, got.has_byte, got.string_end, got.last);
          errors++;
        end
      end
    end
  end

  function automatic logic [4:0] hex_lookup(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - 8'h30)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - 8'h57)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - 8'h37)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (upper ? 8'h37 : 8'h57) + 8'(v);
  endfunction

  function automatic void add_result(input logic [7:0] b, input logic has, input logic fin);
    result_t r;
    r.data = has ? b : 8'h00;
    r.has_byte = has;
    r.string_end = fin;
    r.last = 1'b0;
    run_results.push_back(r);
  endfunction

  function automatic void decode_plain(input logic [7:0] c);
    dec_mode = MODE_NORMAL;
    if (c == CH_NUL || c == CH_QUOTE) begin
      add_result(8'h00, 1'b0, 1'b1);
    end else if (c == CH_BSL) begin
      dec_mode = MODE_ESC;
    end else begin
      add_result(c, 1'b1, 1'b0);
    end
  endfunction

  // Works out the results of one accepted byte and queues them.
  function automatic void decode_byte(input logic [7:0] c);
    logic [4:0]  h;
    logic [4:0]  h0;
    logic [4:0]  h1;
    logic [4:0]  h2;
    logic [15:0] cp;
    run_results.delete();
    h = hex_lookup(c);
    case (dec_mode)
      MODE_ESC: begin
        dec_mode = MODE_NORMAL;
        if (c == CH_NUL) begin
          add_result(8'h00, 1'b0, 1'b1);
        end else if (c == CH_N) begin
          add_result(CH_LF, 1'b1, 1'b0);
        end else if (c == CH_T) begin
          add_result(CH_TAB, 1'b1, 1'b0);
        end else if (c == CH_U) begin
          dec_mode = MODE_HEX;
          hex_count = 2'd0;
        end else begin
          add_result(c, 1'b1, 1'b0);
        end
      end
      MODE_HEX: begin
        if (h[4]) begin
          if (hex_count < 2'd3) begin
            held_hex[hex_count] = c;
            hex_count = hex_count + 2'd1;
          end else begin
            h0 = hex_lookup(held_hex[0]);
            h1 = hex_lookup(held_hex[1]);
            h2 = hex_lookup(held_hex[2]);
            cp = {h0[3:0], h1[3:0], h2[3:0], h[3:0]};
            if (cp == 16'h0000) begin
            end else if (cp < 16'h0080) begin
              add_result(cp[7:0], 1'b1, 1'b0);
            end else if (cp < 16'h0800) begin
              add_result({3'b110, cp[10:6]}, 1'b1, 1'b0);
              add_result({2'b10, cp[5:0]}, 1'b1, 1'b0);
            end else begin
              add_result({4'b1110, cp[15:12]}, 1'b1, 1'b0);
              add_result({2'b10, cp[11:6]}, 1'b1, 1'b0);
              add_result({2'b10, cp[5:0]}, 1'b1, 1'b0);
            end
            dec_mode = MODE_NORMAL;
            hex_count = 2'd0;
          end
        end else begin
          add_result(CH_U, 1'b1, 1'b0);
          for (int i = 0; i < int'(hex_count); i++) add_result(held_hex[i], 1'b1, 1'b0);
          hex_count = 2'd0;
          decode_plain(c);
        end
      end
      default: decode_plain(c);
    endcase
    if (run_results.size() > 0) run_results[run_results.size() - 1].last = 1'b1;
    foreach (run_results[i]) pending_results.push_back(run_results[i]);
  endfunction

  // Sends one request; the sender may pause between bursts of random length.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    decode_byte(b);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_unicode(input logic [15:0] cp, input logic [3:0] upper);
    send_byte(CH_BSL);
    send_byte(CH_U);
    send_byte(hex_char(cp[15:12], upper[3]));
    send_byte(hex_char(cp[11:8], upper[2]));
    send_byte(hex_char(cp[7:4], upper[1]));
    send_byte(hex_char(cp[3:0], upper[0]));
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSL);
    return c;
  endfunction

  task automatic test_plain_bytes();
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(CH_QUOTE);
    send_byte(CH_NUL);
  endtask

  task automatic test_simple_escapes();
    send_byte(CH_BSL);
    send_byte(CH_N);
    send_byte(CH_BSL);
    send_byte(CH_T);
    send_byte(CH_BSL);
    send_byte(CH_BSL);
    send_byte(CH_BSL);
    send_byte(8'hFF);
    send_byte(CH_BSL);
    send_byte(CH_NUL);
  endtask

  task automatic test_unicode_escapes();
    send_unicode(16'hFFFF, 4'b1010);
    send_unicode(16'h0000, 4'b0000);
  endtask

  task automatic test_broken_escape();
    send_byte(CH_BSL);
    send_byte(CH_U);
    send_byte("A");
    send_byte("b");
    send_byte("9");
    send_byte(CH_QUOTE);
  endtask

  // A run of random segments, ending in a quote or a zero byte.
  task automatic send_random_string();
    int          segments;
    int          digits;
    logic [15:0] cp;
    logic [7:0]  c;
    logic [4:0]  hl;
    segments = $urandom_range(0, 8);
    repeat (segments) begin
      case ($urandom_range(0, 9))
        4: begin
          send_byte(CH_BSL);
          case ($urandom_range(0, 6))
            0: send_byte(CH_N);
            1: send_byte(CH_T);
            2: send_byte(CH_SLASH);
            3: send_byte(CH_QUOTE);
            4: send_byte(CH_BSL);
            5: send_byte(CH_NUL);
            default: begin
              do c = plain_char(); while (c == CH_U);
              send_byte(c);
            end
          endcase
        end
        5, 6: begin
          case ($urandom_range(0, 5))
            0: cp = 16'($urandom_range(16'h0001, 16'h007F));
            1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
            2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            3: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
            4: cp = 16'h0000;
            default: cp = 16'($urandom);
          endcase
          send_unicode(cp, 4'($urandom));
        end
        7: begin
          send_byte(CH_BSL);
          send_byte(CH_U);
          digits = $urandom_range(0, 3);
          repeat (digits) send_byte(hex_char(4'($urandom), 1'($urandom)));
          case ($urandom_range(0, 4))
            0: send_byte(CH_QUOTE);
            1: send_byte(CH_NUL);
            2: begin
              send_byte(CH_BSL);
              send_byte(CH_N);
            end
            3: send_byte("g");
            default: begin
              do begin
                c = plain_char();
                hl = hex_lookup(c);
              end while (hl[4]);
              send_byte(c);
            end
          endcase
        end
        8: send_byte(8'($urandom_range(0, 255)));
        default: send_byte(plain_char());
      endcase
    end
    send_byte($urandom_range(0, 1) ? CH_QUOTE : CH_NUL);
  endtask

  task automatic test_random_strings();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) send_random_string();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_bytes();
    test_simple_escapes();
    test_unicode_escapes();
    test_broken_escape();
    test_random_strings();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
